/* design/scfd_pkg.sv */
// Shared types and constants for the sum-checked frame deframer.
// No dependencies; imported by sum_checked_frame_deframer_unit.
`default_nettype none

package scfd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] SYNC_SUM    = SYNC_FIRST + SYNC_SECOND;

  localparam logic [15:0] MAX_LEN_RESET = 16'd56;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_GOOD       = 3'd1,
    KIND_HEADER_ERR = 3'd2,
    KIND_LENGTH_ERR = 3'd3,
    KIND_CHECK_ERR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  command;
    logic [7:0]  version;
    logic [15:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

/* design/sum_checked_frame_deframer_unit.sv */
// Each result is registered into head, or into skid while head is stalled.
// Throughput: one byte per cycle while in_stall is low; parser state is registered.
// A two-entry output queue (head plus skid) keeps bytes flowing while a result waits.
// Reset (rst, synchronous): hunting for the first sync byte, queue empty,
// max_payload_length back to 56.
// Sync-word / length / checksum deframer top level; uses scfd_pkg.
`default_nettype none

module sum_checked_frame_deframer_unit
  import scfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // received bytes
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        burst_end,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       payload_byte,
  output logic [7:0]       command,
  output logic [7:0]       version,
  output logic [15:0]      payload_length,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] max_payload_length
);

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_VERSION = 4'd2,
    PH_COMMAND = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHECK   = 4'd7,
    PH_IGNORE  = 4'd8
  } phase_t;

  phase_t      phase, phase_next, step_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  frame_version, frame_version_next;
  logic [15:0] max_len;

  result_t res;
  logic    res_valid;
  logic    frame_known;
  kind_t   res_kind;

  result_t head, skid;
  logic    skid_valid;

  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  always_comb begin
    step_next            = PH_HUNT1;
    running_sum_next     = running_sum;
    frame_length_next    = frame_length;
    bytes_remaining_next = bytes_remaining;
    frame_command_next   = frame_command;
    frame_version_next   = frame_version;
    res_valid            = 1'b0;
    res_kind             = KIND_HEADER_ERR;
    frame_known          = 1'b0;
    res.payload_byte     = 8'd0;

    unique case (phase)
      PH_HUNT2: begin
        if (rx_byte == SYNC_SECOND) begin
          running_sum_next     = SYNC_SUM;
          frame_length_next    = 16'd0;
          frame_command_next   = 8'd0;
          frame_version_next   = 8'd0;
          bytes_remaining_next = 16'd0;
          step_next            = PH_VERSION;
        end else begin
          step_next = (rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end
        res_valid = burst_end;
      end
      PH_VERSION: begin
        frame_version_next = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        step_next          = PH_COMMAND;
        res_valid          = burst_end;
      end
      PH_COMMAND: begin
        frame_command_next = rx_byte;
        running_sum_next   = running_sum + rx_byte;
        step_next          = PH_LEN_HI;
        res_valid          = burst_end;
      end
      PH_LEN_HI: begin
        frame_length_next = {rx_byte, 8'd0};
        running_sum_next  = running_sum + rx_byte;
        step_next         = PH_LEN_LO;
        res_valid         = burst_end;
      end
      PH_LEN_LO: begin
        frame_length_next    = {frame_length[15:8], rx_byte};
        running_sum_next     = running_sum + rx_byte;
        bytes_remaining_next = frame_length_next;
        if (frame_length_next > max_len || burst_end) begin
          res_valid   = 1'b1;
          res_kind    = KIND_LENGTH_ERR;
          frame_known = 1'b1;
          step_next   = PH_IGNORE;
        end else begin
          step_next = (frame_length_next == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_sum_next     = running_sum + rx_byte;
        bytes_remaining_next = bytes_remaining - 16'd1;
        res_valid            = 1'b1;
        frame_known          = 1'b1;
        if (burst_end) begin
          res_kind  = KIND_LENGTH_ERR;
          step_next = PH_IGNORE;
        end else begin
          res_kind         = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
          step_next = (bytes_remaining_next == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_CHECK: begin
        res_valid   = 1'b1;
        frame_known = 1'b1;
        res_kind    = (rx_byte == running_sum) ? KIND_GOOD : KIND_CHECK_ERR;
        step_next   = PH_IGNORE;
      end
      PH_IGNORE: begin
        step_next = PH_IGNORE;
      end
      default: begin
        // hunting for the first sync byte, and codes that mean nothing
        step_next = (rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        res_valid = burst_end;
      end
    endcase

    phase_next         = burst_end ? PH_HUNT1 : step_next;
    res.kind           = res_kind;
    res.command        = frame_known ? frame_command_next : 8'd0;
    res.version        = frame_known ? frame_version_next : 8'd0;
    res.payload_length = frame_known ? frame_length_next  : 16'd0;
  end

  // parser state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT1;
      running_sum     <= 8'd0;
      frame_length    <= 16'd0;
      bytes_remaining <= 16'd0;
      frame_command   <= 8'd0;
      frame_version   <= 8'd0;
      max_len         <= MAX_LEN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_len <= max_payload_length;
      end
      if (in_fire) begin
        phase           <= phase_next;
        running_sum     <= running_sum_next;
        frame_length    <= frame_length_next;
        bytes_remaining <= bytes_remaining_next;
        frame_command   <= frame_command_next;
        frame_version   <= frame_version_next;
      end
    end
  end

  // output queue: head drives the ports, skid catches a beat while head is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          head       <= skid;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (in_fire && res_valid) begin
          head      <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign kind           = head.kind;
  assign payload_byte   = head.payload_byte;
  assign command        = head.command;
  assign version        = head.version;
  assign payload_length = head.payload_length;

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty head");

  a_burst_end_rehunts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && burst_end) |=> (phase == PH_HUNT1))
    else $error("burst end did not return parser to hunting");

  a_payload_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_PAYLOAD)) |-> (payload_byte == 8'd0))
    else $error("payload byte nonzero on a status result");

  a_header_err_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_HEADER_ERR)) |-> (payload_length == 16'd0))
    else $error("header error carries a length");
`endif

endmodule

`default_nettype wire
